// ===== src/dns_query_name_extractor_macros.svh =====
// Shared assertion macros for the query name extractor.
`ifndef DNS_QUERY_NAME_EXTRACTOR_MACROS_SVH
`define DNS_QUERY_NAME_EXTRACTOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define DQN_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dqn check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define DQN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dqn check failed");

`endif

// ===== src/dqn_pkg.sv =====
package dqn_pkg;

   localparam int BYTE_W      = 8;
   localparam int PORT_W      = 16;
   localparam int KIND_W      = 3;
   localparam int NAME_CNT_W  = 8;

   localparam int NAME_LIMIT_DEFAULT = 255;
   localparam logic [PORT_W-1:0] DNS_PORT_RESET = 16'd53;

   // Result queue; must be a power of two and hold at least two beats.
   localparam int RSP_DEPTH = 4;

   typedef enum logic [KIND_W-1:0] {
      KIND_CHAR     = 3'd0,
      KIND_COMPLETE = 3'd1,
      KIND_NOT_DNS  = 3'd2,
      KIND_TRUNC    = 3'd3,
      KIND_OVERFLOW = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] name_char;
      logic              verdict_last;
   } rsp_item_type;

   // Up to two result beats produced by one frame byte.
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } rsp_pair_type;

endpackage

// ===== src/dqn_req_if.sv =====
interface dqn_req_if;
   logic                      valid;
   logic                      ready;
   logic [dqn_pkg::BYTE_W-1:0] frame_byte;
   logic                      frame_last;

   modport source (output valid, output frame_byte, output frame_last, input ready);
   modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

// ===== src/dqn_rsp_if.sv =====
interface dqn_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [dqn_pkg::KIND_W-1:0] kind;
   logic [dqn_pkg::BYTE_W-1:0] name_char;
   logic                      verdict_last;

   modport source (output valid, output kind, output name_char, output verdict_last,
                   input ready);
   modport sink   (input valid, input kind, input name_char, input verdict_last,
                   output ready);
endinterface

// ===== src/dqn_step.sv =====
module dqn_step #(
   parameter int NAME_LIMIT = dqn_pkg::NAME_LIMIT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [dqn_pkg::BYTE_W-1:0]    frame_byte,
   input  logic                          frame_last,
   input  logic [dqn_pkg::PORT_W-1:0]    dns_port,
   output dqn_pkg::rsp_pair_type         results
);
   import dqn_pkg::*;

   localparam logic [15:0] ETH_LEN   = 16'd14;
   localparam logic [15:0] PROTO_POS = 16'd23;
   localparam logic [15:0] PORT_OFS  = 16'd2;
   localparam logic [15:0] NAME_OFS  = 16'd20;
   localparam logic [BYTE_W-1:0] PROTO_UDP = 8'd17;
   localparam logic [BYTE_W-1:0] DOT_CHAR  = 8'h2E;
   localparam logic [NAME_CNT_W-1:0] LIMIT = NAME_CNT_W'(NAME_LIMIT);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_LEN,
      PH_LABEL,
      PH_DONE
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [15:0]           pos_ff, pos_in;
   logic [6:0]            udp_start_ff, udp_start_in;
   logic [BYTE_W-1:0]     port_high_ff, port_high_in;
   logic [BYTE_W-1:0]     label_left_ff, label_left_in;
   logic [NAME_CNT_W-1:0] name_count_ff, name_count_in;
   logic                  first_label_ff, first_label_in;

   logic         main_valid;
   rsp_item_type main_item;
   logic         trunc_valid;
   rsp_item_type trunc_item;
   logic [15:0]  us_pos;

   always_comb begin
      us_pos         = {9'd0, udp_start_ff};
      phase_in       = phase_ff;
      udp_start_in   = udp_start_ff;
      port_high_in   = port_high_ff;
      label_left_in  = label_left_ff;
      name_count_in  = name_count_ff;
      first_label_in = first_label_ff;
      main_valid     = 1'b0;
      main_item      = '{kind: KIND_CHAR, name_char: '0, verdict_last: 1'b0};
      trunc_item     = '{kind: KIND_TRUNC, name_char: '0, verdict_last: 1'b1};

      unique case (phase_ff)
         PH_HEADER: begin
            priority if (pos_ff == ETH_LEN) begin
               if (frame_byte[3:0] < 4'd5) begin
                  main_valid     = 1'b1;
                  main_item.kind = KIND_NOT_DNS;
               end else begin
                  udp_start_in = 7'd14 + {1'b0, frame_byte[3:0], 2'b00};
               end
            end else if (pos_ff == PROTO_POS) begin
               if (frame_byte != PROTO_UDP) begin
                  main_valid     = 1'b1;
                  main_item.kind = KIND_NOT_DNS;
               end
            end else if (pos_ff > PROTO_POS) begin
               priority if (pos_ff == us_pos + PORT_OFS) begin
                  port_high_in = frame_byte;
               end else if (pos_ff == us_pos + PORT_OFS + 16'd1) begin
                  if ({port_high_ff, frame_byte} != dns_port) begin
                     main_valid     = 1'b1;
                     main_item.kind = KIND_NOT_DNS;
                  end
               end else if (pos_ff == us_pos + NAME_OFS - 16'd1) begin
                  phase_in = PH_LEN;
               end else begin
                  phase_in = PH_HEADER;
               end
            end else begin
               phase_in = PH_HEADER;
            end
         end
         PH_LEN: begin
            if (frame_byte == '0) begin
               main_valid     = 1'b1;
               main_item.kind = KIND_COMPLETE;
            end else if (!first_label_ff && (name_count_ff >= LIMIT)) begin
               main_valid     = 1'b1;
               main_item.kind = KIND_OVERFLOW;
            end else begin
               if (!first_label_ff) begin
                  main_valid          = 1'b1;
                  main_item.name_char = DOT_CHAR;
                  name_count_in       = name_count_ff + NAME_CNT_W'(1);
               end
               first_label_in = 1'b0;
               label_left_in  = frame_byte;
               phase_in       = PH_LABEL;
            end
         end
         PH_LABEL: begin
            main_valid = 1'b1;
            if (name_count_ff >= LIMIT) begin
               main_item.kind = KIND_OVERFLOW;
            end else begin
               main_item.name_char = frame_byte;
               name_count_in       = name_count_ff + NAME_CNT_W'(1);
               label_left_in       = label_left_ff - 8'd1;
               if (label_left_ff == 8'd1) begin
                  phase_in = PH_LEN;
               end
            end
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase

      // Any verdict ends the frame's run of results.
      if (main_valid && (main_item.kind != KIND_CHAR)) begin
         main_item.verdict_last = 1'b1;
         phase_in               = PH_DONE;
      end

      pos_in = (pos_ff != 16'hFFFF) ? pos_ff + 16'd1 : pos_ff;

      trunc_valid = frame_last && (phase_in != PH_DONE);
      if (frame_last) begin
         pos_in         = '0;
         udp_start_in   = '0;
         phase_in       = PH_HEADER;
         port_high_in   = '0;
         label_left_in  = '0;
         name_count_in  = '0;
         first_label_in = 1'b1;
      end

      results.item0 = main_valid ? main_item : trunc_item;
      results.item1 = trunc_item;
      results.count = accept ? ({1'b0, main_valid} + {1'b0, trunc_valid}) : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEADER;
         pos_ff         <= '0;
         udp_start_ff   <= '0;
         port_high_ff   <= '0;
         label_left_ff  <= '0;
         name_count_ff  <= '0;
         first_label_ff <= 1'b1;
      end else if (accept) begin
         phase_ff       <= phase_in;
         pos_ff         <= pos_in;
         udp_start_ff   <= udp_start_in;
         port_high_ff   <= port_high_in;
         label_left_ff  <= label_left_in;
         name_count_ff  <= name_count_in;
         first_label_ff <= first_label_in;
      end
   end

endmodule

// ===== src/dqn_rsp_fifo.sv =====
module dqn_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  dqn_pkg::rsp_pair_type push,
   input  logic                  pop,
   output dqn_pkg::rsp_item_type head,
   output logic                  head_valid,
   output logic                  has_room
);
   import dqn_pkg::*;

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   rsp_item_type      mem_ff [RSP_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PTR_W-1:0]  wr_next;

   assign wr_next    = wr_ptr_ff + PTR_W'(1);
   assign head       = mem_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   // Room for a two-beat burst from one byte.
   assign has_room   = (count_ff <= CNT_W'(RSP_DEPTH - 2));
   assign count_in   = count_ff + CNT_W'(push.count) - CNT_W'(pop && head_valid);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(push.count);
         if (pop && head_valid) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

// ===== src/dns_query_name_extractor.sv =====
// Channel  | Dir | Beat
// ---------+-----+--------------------------------------------------------
// req_chan | in  | frame_byte, frame_last: one frame byte, Ethernet first
// rsp_chan | out | kind, name_char, verdict_last: name char or verdict
// csr_*    | in  | csr_wr_en, csr_wr_data: write of dns_port
//
// One frame byte is taken per cycle while the queue has room; its state update finishes in that same cycle.
// Each byte yields zero, one or two result beats, written into a four-beat queue.
// req_chan.ready is high while the queue has room for two beats, so a stalled
// result side holds off the request side after three or four beats pile up.
// Results reach rsp_chan through the registered result queue, behind any beats already waiting in it.
// Reset (synchronous, active high) clears per-frame state, empties the queue
// and sets dns_port to 53.
module dns_query_name_extractor #(
   parameter int NAME_LIMIT = dqn_pkg::NAME_LIMIT_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   dqn_req_if.sink                    req_chan,
   dqn_rsp_if.source                  rsp_chan,
   input  logic                       csr_wr_en,
   input  logic [dqn_pkg::PORT_W-1:0] csr_wr_data
);
   import dqn_pkg::*;

   logic [PORT_W-1:0] dns_port_ff;
   logic              req_accept;
   logic              queue_room;
   rsp_pair_type      step_results;
   rsp_item_type      head_item;
   logic              head_valid;

   // Hold the DNS port; software is to write it only between frames, which the block itself does not enforce.
   always_ff @(posedge clock) begin
      if (reset) begin
         dns_port_ff <= DNS_PORT_RESET;
      end else if (csr_wr_en) begin
         dns_port_ff <= csr_wr_data;
      end
   end

   // Advance on every byte beat while the queue can absorb a worst-case burst.
   assign req_chan.ready = queue_room;
   assign req_accept     = req_chan.valid && queue_room;

   dqn_step #(
      .NAME_LIMIT (NAME_LIMIT)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .frame_byte (req_chan.frame_byte),
      .frame_last (req_chan.frame_last),
      .dns_port   (dns_port_ff),
      .results    (step_results)
   );

   // Queue result beats so a stall on rsp_chan never drops one.
   dqn_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (step_results),
      .pop        (rsp_chan.ready),
      .head       (head_item),
      .head_valid (head_valid),
      .has_room   (queue_room)
   );

   assign rsp_chan.valid        = head_valid;
   assign rsp_chan.kind         = head_item.kind;
   assign rsp_chan.name_char    = head_item.name_char;
   assign rsp_chan.verdict_last = head_item.verdict_last;

endmodule

// ===== src/dqn_checker.sv =====
`include "dns_query_name_extractor_macros.svh"

module dqn_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [dqn_pkg::KIND_W-1:0] rsp_kind,
   input logic [dqn_pkg::BYTE_W-1:0] rsp_name_char,
   input logic                       rsp_verdict_last
);
   import dqn_pkg::*;

   `DQN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_name_char) && $stable(rsp_verdict_last))

   `DQN_ASSERT_NOW(a_char_not_last, clock, reset, rsp_valid && (rsp_kind == KIND_CHAR), !rsp_verdict_last)

   `DQN_ASSERT_NOW(a_verdict_shape, clock, reset, rsp_valid && (rsp_kind != KIND_CHAR), rsp_verdict_last && (rsp_name_char == '0))

   `DQN_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind dns_query_name_extractor dqn_checker u_dqn_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_kind         (rsp_chan.kind),
   .rsp_name_char    (rsp_chan.name_char),
   .rsp_verdict_last (rsp_chan.verdict_last)
);

// ===== dv/dqn_name_checker.sv =====
`timescale 1ns / 1ps

module dqn_name_checker #(
   parameter int NAME_LIMIT = dqn_pkg::NAME_LIMIT_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   dqn_req_if                         req_mon,
   dqn_rsp_if                         rsp_mon,
   input  logic                       csr_wr_en,
   input  logic [dqn_pkg::PORT_W-1:0] csr_wr_data,
   output int                         mismatch_count,
   output int                         beats_due,
   output int                         beats_checked
);
   import dqn_pkg::*;

   localparam int               ETH_HDR_LEN  = 14;
   localparam int               IP_PROTO_POS = 23;
   localparam logic [7:0]       UDP_PROTO_ID = 8'd17;
   localparam int               DST_PORT_OFS = 2;
   localparam int               QNAME_OFS    = 20;
   localparam logic [7:0]       DOT_CHAR     = 8'h2E;

   typedef enum logic [1:0] {
      SCAN_HEADER,
      SCAN_LENGTH,
      SCAN_LABEL,
      SCAN_DONE
   } scan_phase_type;

   logic [PORT_W-1:0] dns_port_q;
   logic [15:0]       frame_pos;
   logic [6:0]        udp_ofs;
   scan_phase_type    scan;
   logic [7:0]        port_hi;
   logic [7:0]        label_left;
   logic [7:0]        name_len;
   logic              first_label;

   rsp_item_type      name_beats_due[$];

   task automatic clear_frame();
      frame_pos   = '0;
      udp_ofs     = '0;
      scan        = SCAN_HEADER;
      port_hi     = '0;
      label_left  = '0;
      name_len    = '0;
      first_label = 1'b1;
   endtask

   task automatic push_char(input logic [7:0] c);
      name_beats_due.push_back('{kind: KIND_CHAR, name_char: c, verdict_last: 1'b0});
      name_len++;
   endtask

   task automatic give_verdict(input kind_type k);
      name_beats_due.push_back('{kind: k, name_char: 8'h00, verdict_last: 1'b1});
      scan = SCAN_DONE;
   endtask

   // Advance the frame parser by one byte and queue the beats it yields.
   task automatic predict_name_beats(input logic [7:0] b, input logic last);
      int pos;
      int us;
      pos = frame_pos;
      us  = udp_ofs;
      case (scan)
         SCAN_HEADER: begin
            if (pos == ETH_HDR_LEN) begin
               if (b[3:0] < 4'd5) give_verdict(KIND_NOT_DNS);
               else udp_ofs = 7'(ETH_HDR_LEN + 4 * int'(b[3:0]));
            end else if (pos == IP_PROTO_POS) begin
               if (b != UDP_PROTO_ID) give_verdict(KIND_NOT_DNS);
            end else if (pos > IP_PROTO_POS) begin
               if (pos == us + DST_PORT_OFS) begin
                  port_hi = b;
               end else if (pos == us + DST_PORT_OFS + 1) begin
                  if ({port_hi, b} != dns_port_q) give_verdict(KIND_NOT_DNS);
               end else if (pos == us + QNAME_OFS - 1) begin
                  scan = SCAN_LENGTH;
               end
            end
         end
         SCAN_LENGTH: begin
            if (b == 8'd0) begin
               give_verdict(KIND_COMPLETE);
            end else if (!first_label && name_len >= NAME_LIMIT) begin
               give_verdict(KIND_OVERFLOW);
            end else begin
               if (!first_label) push_char(DOT_CHAR);
               first_label = 1'b0;
               label_left  = b;
               scan        = SCAN_LABEL;
            end
         end
         SCAN_LABEL: begin
            if (name_len >= NAME_LIMIT) begin
               give_verdict(KIND_OVERFLOW);
            end else begin
               push_char(b);
               label_left--;
               if (label_left == 8'd0) scan = SCAN_LENGTH;
            end
         end
         default: ;
      endcase
      if (frame_pos != 16'hFFFF) frame_pos++;
      if (last) begin
         if (scan != SCAN_DONE) give_verdict(KIND_TRUNC);
         clear_frame();
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         dns_port_q = DNS_PORT_RESET;
         clear_frame();
         name_beats_due.delete();
         mismatch_count = 0;
         beats_checked  = 0;
      end else begin
         if (csr_wr_en) dns_port_q = csr_wr_data;
         if (req_mon.valid && req_mon.ready)
            predict_name_beats(req_mon.frame_byte, req_mon.frame_last);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (name_beats_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: result beat with none expected: kind %0d char %02h last %0b",
                        $time, rsp_mon.kind, rsp_mon.name_char, rsp_mon.verdict_last);
            end else begin
               want = name_beats_due.pop_front();
               beats_checked++;
               if (rsp_mon.kind != want.kind) begin
                  mismatch_count++;
                  $display("%0t: kind expected %0d actual %0d",
                           $time, want.kind, rsp_mon.kind);
               end
               if (rsp_mon.name_char != want.name_char) begin
                  mismatch_count++;
                  $display("%0t: name_char expected %02h actual %02h",
                           $time, want.name_char, rsp_mon.name_char);
               end
               if (rsp_mon.verdict_last != want.verdict_last) begin
                  mismatch_count++;
                  $display("%0t: verdict_last expected %0b actual %0b",
                           $time, want.verdict_last, rsp_mon.verdict_last);
               end
            end
         end
      end
      beats_due <= name_beats_due.size();
   end

endmodule

// ===== dv/tb_dns_query_name_extractor.sv =====
`timescale 1ns / 1ps

module tb_dns_query_name_extractor;
   import dqn_pkg::*;

   localparam int         CYCLE_LIMIT   = 200000;
   localparam int         ETH_LEN_BYTES = 14;
   localparam logic [7:0] UDP_PROTO_ID  = 8'd17;
   localparam logic [7:0] TCP_PROTO_ID  = 8'd6;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en;
   logic [PORT_W-1:0] csr_wr_data;
   logic              rsp_take = 1'b0;
   logic              steady = 1'b0;     // high: no idling on either side
   logic [PORT_W-1:0] cur_port = DNS_PORT_RESET;

   logic [7:0]        frame_q[$];        // bytes of the frame being built
   int                bytes_sent = 0;
   int                frames_sent = 0;
   int                port_settings = 1;
   int                cycle_count = 0;

   int                mismatch_count;
   int                beats_due;
   int                beats_checked;

   dqn_req_if req_chan ();
   dqn_rsp_if rsp_chan ();

   assign rsp_chan.ready = rsp_take;

   dns_query_name_extractor uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   dqn_name_checker name_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .beats_due      (beats_due),
      .beats_checked  (beats_checked)
   );

   always #2 clock = ~clock;

   // Stall the result side about a third of the time, except in the steady stretch.
   always @(posedge clock) begin
      rsp_take <= steady || ($urandom_range(0, 99) >= 34);
   end

   // Watchdog: a hung handshake or a lost beat ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d beats still due", cycle_count, beats_due);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Offer one byte, idling first at random; hold it until the block takes the beat.
   task automatic send_byte(input logic [7:0] b, input logic last);
      while (!steady && $urandom_range(0, 99) < 34) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.frame_byte <= b;
      req_chan.frame_last <= last;
      do @(posedge clock); while (!req_chan.ready);
      bytes_sent++;
   endtask

   // Send the built frame; a nonzero cut ends it early at that many bytes.
   task automatic send_frame(input int cut);
      int total;
      total = (cut > 0 && cut < frame_q.size()) ? cut : frame_q.size();
      for (int i = 0; i < total; i++) send_byte(frame_q[i], i == total - 1);
      frames_sent++;
   endtask

   task automatic add_random(input int n);
      repeat (n) frame_q.push_back(8'($urandom));
   endtask

   task automatic add_label(input int len);
      frame_q.push_back(8'(len));
      add_random(len);
   endtask

   // Ethernet, IPv4 (IHL words), UDP and DNS headers; the name goes after them.
   task automatic start_frame(input logic [3:0] ihl, input logic [7:0] proto,
                              input logic [15:0] dport);
      frame_q.delete();
      add_random(ETH_LEN_BYTES);
      frame_q.push_back({4'($urandom), ihl});
      add_random(8);
      frame_q.push_back(proto);
      if (ihl >= 4'd5) begin
         add_random(4 * int'(ihl) - 10);
         add_random(2);                  // source port
         frame_q.push_back(dport[15:8]);
         frame_q.push_back(dport[7:0]);
         add_random(4 + 12);             // UDP length/checksum, DNS header
      end else begin
         add_random(30);
      end
   endtask

   // Add a short random name; now and then a label of 64 or more bytes.
   task automatic add_short_name();
      repeat ($urandom_range(0, 4))
         add_label(($urandom_range(0, 9) == 0) ? $urandom_range(64, 255)
                                               : $urandom_range(1, 20));
      frame_q.push_back(8'd0);
   endtask

   // Drain every due beat, then let the pipeline go quiet before a register write.
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (beats_due != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_port(input logic [15:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cur_port = value;
      port_settings++;
   endtask

   task automatic random_frame();
      int          r;
      int          cut;
      logic [7:0]  proto;
      logic [15:0] dport;
      r     = $urandom_range(0, 99);
      cut   = 0;
      proto = 8'($urandom);
      if (proto == UDP_PROTO_ID) proto = TCP_PROTO_ID;
      dport = cur_port ^ (16'd1 << $urandom_range(0, 15));
      if (r < 60) begin
         // Well-formed query; some names run up against the name limit.
         start_frame(4'($urandom_range(5, 15)), UDP_PROTO_ID, cur_port);
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(3, 5)) add_label($urandom_range(50, 70));
            frame_q.push_back(8'd0);
         end else begin
            add_short_name();
         end
         add_random($urandom_range(0, 6));
         if ($urandom_range(0, 4) == 0) cut = $urandom_range(1, frame_q.size());
      end else if (r < 70) begin
         start_frame(4'($urandom_range(5, 15)), proto, cur_port);
         add_short_name();
      end else if (r < 80) begin
         start_frame(4'($urandom_range(5, 15)), UDP_PROTO_ID, dport);
         add_short_name();
      end else if (r < 85) begin
         start_frame(4'($urandom_range(0, 4)), UDP_PROTO_ID, cur_port);
      end else begin
         // Noise: random bytes of random length, often ending inside the header.
         frame_q.delete();
         add_random($urandom_range(1, 60));
      end
      send_frame(cut);
   endtask

   initial begin
      int          cut_at;
      int          phase_start;
      logic [15:0] phase_ports[3];
      int          phase_bytes[3];

      req_chan.valid      <= 1'b0;
      req_chan.frame_byte <= 8'h00;
      req_chan.frame_last <= 1'b0;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames, dns_port at its reset value.
      // Label bytes 00 and FF are plain characters; trailing bytes follow the terminator.
      start_frame(4'd5, UDP_PROTO_ID, cur_port);
      frame_q.push_back(8'd2);
      frame_q.push_back(8'h00);
      frame_q.push_back(8'hFF);
      add_label(3);
      frame_q.push_back(8'd0);
      add_random(4);
      send_frame(0);
      // Short IHL, just below the minimum.
      start_frame(4'd4, UDP_PROTO_ID, cur_port);
      send_frame(0);
      // Not UDP.
      start_frame(4'd5, TCP_PROTO_ID, cur_port);
      add_label(3);
      frame_q.push_back(8'd0);
      send_frame(0);
      // Wrong port in the low byte behind a longer IP header.
      start_frame(4'd6, UDP_PROTO_ID, cur_port ^ 16'h0001);
      add_label(3);
      frame_q.push_back(8'd0);
      send_frame(0);
      // Name at the limit, then another label: the dot overflows.
      start_frame(4'd5, UDP_PROTO_ID, cur_port);
      add_label(255); add_label(1);
      frame_q.push_back(8'd0);
      send_frame(0);
      // Overflow inside a label, on its last byte.
      start_frame(4'd5, UDP_PROTO_ID, cur_port);
      repeat (3) add_label(63);
      add_label(64);
      frame_q.push_back(8'd0);
      send_frame(0);
      // Truncated on a later length byte: dot, then the truncated verdict.
      start_frame(4'd5, UDP_PROTO_ID, cur_port);
      add_label(3);
      cut_at = frame_q.size();
      add_label(4);
      frame_q.push_back(8'd0);
      send_frame(cut_at + 1);
      // Truncated inside the headers: on the protocol byte and on a one-byte frame.
      start_frame(4'd5, UDP_PROTO_ID, cur_port);
      send_frame(24);
      frame_q.delete();
      add_random(1);
      send_frame(0);

      // Random frames over several port settings, extremes first; the last
      // setting runs with no idling on either side.
      phase_ports[0] = 16'h0000;
      phase_ports[1] = 16'hFFFF;
      phase_ports[2] = 16'($urandom);
      phase_bytes[0] = 40;
      phase_bytes[1] = 40;
      phase_bytes[2] = 150;
      for (int p = 0; p < 3; p++) begin
         set_port(phase_ports[p]);
         steady = (p == 2);
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < phase_bytes[p]) random_frame();
      end
      steady = 1'b0;

      // Drain, then give the block a few more cycles to show a stray beat.
      settle();
      repeat (16) @(posedge clock);

      $display("Sent %0d frames, %0d bytes, over %0d dns_port settings", frames_sent,
               bytes_sent, port_settings);
      $display("Compared %0d result beats: names, limits, bad headers and cut frames",
               beats_checked);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== dns_query_name_extractor.f =====
+incdir+src
src/dqn_pkg.sv
src/dqn_req_if.sv
src/dqn_rsp_if.sv
src/dqn_step.sv
src/dqn_rsp_fifo.sv
src/dns_query_name_extractor.sv
src/dqn_checker.sv
dv/dqn_name_checker.sv
dv/tb_dns_query_name_extractor.sv
